// ===== hdl/sui_pkg.sv =====
// ============================================================================
// sui_pkg
// Shared types and constants for the set union / intersection dedup core.
// ============================================================================
`default_nettype none

package sui_pkg;

    // Element width, fixed by the stream format
    localparam int DATA_W = 32;

    // Stream action codes (carried on tuser)
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_CAND  = 2'd2;

    // Mode register values
    localparam logic MODE_UNION = 1'b0;
    localparam logic MODE_INTER = 1'b1;

    // Register index bit of paddr (registers lie 4 bytes apart)
    localparam logic REG_MODE = 1'b0;

    // Search token handed from cell to cell
    typedef struct packed {
        logic act;      // token present
        logic ref_hit;  // value found in reference store so far
        logic emt_hit;  // value found in emitted store so far
    } t_link;

    // Write strobes broadcast to the row of cells
    typedef struct packed {
        logic ref_we;
        logic emt_we;
    } t_wr;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/sui_cell.sv =====
// ============================================================================
// sui_cell
// One storage cell: holds one reference entry and one emitted entry, and
// folds its compare results into the search token passed down the row.
// ============================================================================
`default_nettype none

module sui_cell
    import sui_pkg::*;
#(
    parameter int AW  = 5,
    parameter int CW  = 6,
    parameter int IDX = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_link             i_link,
    output t_link                  o_link,
    input  wire logic [DATA_W-1:0] i_value,
    input  wire t_wr               i_wr,
    input  wire logic [AW-1:0]     i_wr_idx,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic [CW-1:0]     i_ref_cnt,
    input  wire logic [CW-1:0]     i_emt_cnt
);

    logic [DATA_W-1:0] r_ref;
    logic [DATA_W-1:0] r_emt;
    t_link             r_link;
    t_link             n_link;
    logic              w_sel;
    logic              w_ref_match;
    logic              w_emt_match;

    // Entry is live only below the fill count
    assign w_sel       = (i_wr_idx == AW'(IDX));
    assign w_ref_match = (i_ref_cnt > CW'(IDX)) && (r_ref == i_value);
    assign w_emt_match = (i_emt_cnt > CW'(IDX)) && (r_emt == i_value);

    // Entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr.ref_we && w_sel) begin
            r_ref <= i_wr_data;
        end
        if (i_wr.emt_we && w_sel) begin
            r_emt <= i_wr_data;
        end
    end

    // Token stage
    always_comb begin
        n_link.act     = i_link.act;
        n_link.ref_hit = i_link.act && (i_link.ref_hit || w_ref_match);
        n_link.emt_hit = i_link.act && (i_link.emt_hit || w_emt_match);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    assign o_link = r_link;

endmodule

`default_nettype wire

// ===== hdl/set_union_intersection_dedup_core.sv =====
// A clear, a load into a store with room or an unused action is handled in the idle state.
// A candidate walks a search token through the row of MAX_ELEMS cells, one
// cell per cycle; a candidate that survives the search goes to the output register.
// A load into a full store goes through the emit state and returns an overflow result.
// One item is in work at a time; the output register lets the next be taken.
// Synchronous active-low reset empties both stores and sets union mode.
// ============================================================================
// set_union_intersection_dedup_core
// Streaming set union / intersection with duplicate removal, built on a
// row of compare cells and a small controller.
// ============================================================================
`default_nettype none

module set_union_intersection_dedup_core
    import sui_pkg::*;
#(
    parameter int MAX_ELEMS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input stream
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [31:0]       i_s_axis_tdata,   // [31:0] value
    input  wire logic [1:0]        i_s_axis_tuser,   // [1:0] action
    // Output stream
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [31:0]            o_m_axis_tdata,   // [31:0] result_value
    output logic [0:0]             o_m_axis_tuser,   // [0] overflow
    // Register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CW = $clog2(MAX_ELEMS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_ELEMS);

    t_state              r_state, n_state;
    logic                r_mode;
    logic [CW-1:0]       r_ref_cnt, n_ref_cnt;
    logic [CW-1:0]       r_emt_cnt, n_emt_cnt;
    logic [DATA_W-1:0]   r_value;
    logic                r_ovf, n_ovf;
    logic                r_launch;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_data;
    logic                r_out_ovf;

    logic                w_in_acc;
    logic                w_out_free;
    t_wr                 w_wr;
    logic [AW-1:0]       w_wr_idx;
    logic [DATA_W-1:0]   w_wr_data;
    t_link               w_link [MAX_ELEMS+1];
    logic [MAX_ELEMS-1:0] w_act;
    t_link               w_tail;
    logic                w_keep;

    // ------------------------------------------------------------------
    // Register port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_UNION;
        end else if (psel && penable && pwrite && (paddr[2] == REG_MODE)) begin
            r_mode <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_MODE) ? {31'd0, r_mode} : 32'd0;

    // ------------------------------------------------------------------
    // Handshakes
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    // ------------------------------------------------------------------
    // Row of cells
    assign w_link[0] = '{act: r_launch, ref_hit: 1'b0, emt_hit: 1'b0};

    for (genvar g = 0; g < MAX_ELEMS; g++) begin : g_cell
        sui_cell #(
            .AW  (AW),
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_link    (w_link[g]),
            .o_link    (w_link[g+1]),
            .i_value   (r_value),
            .i_wr      (w_wr),
            .i_wr_idx  (w_wr_idx),
            .i_wr_data (w_wr_data),
            .i_ref_cnt (r_ref_cnt),
            .i_emt_cnt (r_emt_cnt)
        );
        assign w_act[g] = w_link[g+1].act;
    end

    assign w_tail = w_link[MAX_ELEMS];

    // Candidate survives the search: in reference (intersection) and new
    assign w_keep = ((r_mode == MODE_UNION) || w_tail.ref_hit) && !w_tail.emt_hit;

    // ------------------------------------------------------------------
    // Controller
    always_comb begin
        n_state   = r_state;
        n_ref_cnt = r_ref_cnt;
        n_emt_cnt = r_emt_cnt;
        n_ovf     = r_ovf;
        w_wr      = '0;
        w_wr_idx  = r_ref_cnt[AW-1:0];
        w_wr_data = i_s_axis_tdata;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    priority if (i_s_axis_tuser == ACT_CLEAR) begin
                        n_ref_cnt = '0;
                        n_emt_cnt = '0;
                    end else if (i_s_axis_tuser == ACT_LOAD) begin
                        if (r_ref_cnt == FULL) begin
                            n_ovf   = 1'b1;
                            n_state = ST_EMIT;
                        end else begin
                            w_wr.ref_we = 1'b1;
                            n_ref_cnt   = r_ref_cnt + 1'b1;
                        end
                    end else if (i_s_axis_tuser == ACT_CAND) begin
                        n_state = ST_WALK;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_WALK: begin
                w_wr_idx  = r_emt_cnt[AW-1:0];
                w_wr_data = r_value;
                if (w_tail.act) begin
                    if (!w_keep) begin
                        n_state = ST_IDLE;
                    end else if (r_emt_cnt == FULL) begin
                        n_ovf   = 1'b1;
                        n_state = ST_EMIT;
                    end else begin
                        w_wr.emt_we = 1'b1;
                        n_emt_cnt   = r_emt_cnt + 1'b1;
                        n_ovf       = 1'b0;
                        n_state     = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ref_cnt <= '0;
            r_emt_cnt <= '0;
            r_launch  <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ref_cnt <= n_ref_cnt;
            r_emt_cnt <= n_emt_cnt;
            r_launch  <= w_in_acc && (i_s_axis_tuser == ACT_CAND);
            r_ovf     <= n_ovf;
        end
    end

    // Item value, held for the search and the result
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_value <= i_s_axis_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_EMIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && w_out_free) begin
            r_out_data <= r_value;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_ovf;

    // ------------------------------------------------------------------
`ifndef NO_ASSERTIONS
    a_ref_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ref_cnt <= FULL)
        else $error("reference count beyond store depth");

    a_emt_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emt_cnt <= FULL)
        else $error("emitted count beyond store depth");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_act))
        else $error("more than one search token in the cell row");

    a_token_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.act |-> (r_state == ST_WALK))
        else $error("search token finished outside the walk state");

    a_emt_only_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emt_cnt == $past(r_emt_cnt) + 1'b1) && $past(i_rst_n)
            |-> (r_state == ST_EMIT) && !r_ovf)
        else $error("emitted count advanced without a pending result");
`endif

endmodule

`default_nettype wire
